>>> sv/srht_pkg.sv
package srht_pkg;

  // item kinds on the input tuser
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_TICK  = 2'd1;
  localparam kind_t KIND_SLOW  = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_END_SPEED    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FLOOR_SPEED  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RAMP_STEP    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_GYRO_GAIN    = 3'd4;

  // reset values of the registers
  localparam logic [11:0] RampStepRst = 12'd16;
  localparam logic [15:0] GyroGainRst = 16'd256;

  typedef struct packed {
    logic signed [15:0] target_speed;
    logic [14:0]        end_speed;
    logic [14:0]        floor_speed;
    logic [11:0]        ramp_step;
    logic [15:0]        gyro_gain;
  } cfg_t;

  // ramp state after the update of one item
  typedef struct packed {
    logic signed [15:0] running_speed;
    logic               reached;
    logic               slowing;
  } ramp_t;

  // clamp a wide signed value into 16 bit signed
  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    logic signed [15:0] r;
    if (v > 35'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -35'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> sv/srht_ramp.sv
module srht_ramp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  srht_pkg::kind_t      kind_i,
  input  logic signed [15:0]   measured_i,
  input  srht_pkg::cfg_t       cfg_i,
  output srht_pkg::ramp_t      ramp_o
);

  logic signed [15:0] run_q, run_d;
  logic               slow_q, slow_d;
  logic               reach_q, reach_d;

  logic signed [16:0] run_x, tgt_x, abs_run, abs_tgt, step_x, floor_x;
  logic signed [34:0] ramp_sum;
  logic [14:0]        floor_mag;
  logic               tgt_pos;

  assign run_x     = {run_q[15], run_q};
  assign tgt_x     = {cfg_i.target_speed[15], cfg_i.target_speed};
  assign abs_run   = run_q[15] ? -run_x : run_x;
  assign abs_tgt   = cfg_i.target_speed[15] ? -tgt_x : tgt_x;
  assign step_x    = {5'd0, cfg_i.ramp_step};
  assign floor_mag = (cfg_i.end_speed > cfg_i.floor_speed) ? cfg_i.end_speed
                                                            : cfg_i.floor_speed;
  assign floor_x   = {2'd0, floor_mag};
  assign tgt_pos   = !cfg_i.target_speed[15] && (cfg_i.target_speed != 16'sd0);

  // step toward target; the wide sum is saturated to the 16 bit range where it is used
  always_comb begin
    if (tgt_pos) begin
      ramp_sum = 35'(run_x) + 35'(step_x);
    end else begin
      ramp_sum = 35'(run_x) - 35'(step_x);
    end
  end

  // next state for the current item
  always_comb begin
    run_d   = run_q;
    slow_d  = slow_q;
    reach_d = reach_q;
    case (kind_i)
      srht_pkg::KIND_START: begin
        if (tgt_pos) begin
          run_d = measured_i[15] ? 16'sd0 : measured_i;
        end else begin
          run_d = (!measured_i[15] && measured_i != 16'sd0) ? 16'sd0 : measured_i;
        end
        slow_d  = 1'b0;
        reach_d = 1'b0;
      end
      srht_pkg::KIND_SLOW: begin
        slow_d = 1'b1;
      end
      srht_pkg::KIND_TICK: begin
        if (!slow_q) begin
          if (abs_run < abs_tgt) begin
            run_d = srht_pkg::sat16(ramp_sum);
          end else begin
            run_d   = cfg_i.target_speed;
            reach_d = 1'b1;
          end
        end else begin
          reach_d = 1'b1;
          if (run_x > 17'sd0) begin
            run_d = (run_x > floor_x) ? 16'(run_x - step_x) : 16'(floor_x);
          end else begin
            run_d = (run_x < -floor_x) ? 16'(run_x + step_x) : 16'(-floor_x);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ramp state, updated as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      slow_q  <= 1'b0;
      reach_q <= 1'b0;
    end else if (adv_i) begin
      run_q   <= run_d;
      slow_q  <= slow_d;
      reach_q <= reach_d;
    end
  end

  assign ramp_o.running_speed = run_d;
  assign ramp_o.reached       = reach_d;
  assign ramp_o.slowing       = slow_d;

endmodule

>>> sv/srht_trim.sv
module srht_trim (
  input  srht_pkg::kind_t      kind_i,
  input  logic signed [24:0]   err_i,
  input  srht_pkg::cfg_t       cfg_i,
  input  srht_pkg::ramp_t      ramp_i,
  output logic signed [15:0]   left_o,
  output logic signed [15:0]   right_o
);

  logic signed [41:0] prod;
  logic signed [33:0] corr;
  logic signed [34:0] run_w, left_w, right_w;

  // heading correction, floor shift by 8 for the Q8.8 gain
  assign prod    = err_i * $signed({1'b0, cfg_i.gyro_gain});
  assign corr    = prod[41:8];
  assign run_w   = 35'(ramp_i.running_speed);
  assign left_w  = run_w - 35'(corr);
  assign right_w = run_w + 35'(corr);

  // start answers with the plain target, ticks get the trimmed speed
  always_comb begin
    if (kind_i == srht_pkg::KIND_START) begin
      left_o  = cfg_i.target_speed;
      right_o = cfg_i.target_speed;
    end else begin
      left_o  = srht_pkg::sat16(left_w);
      right_o = srht_pkg::sat16(right_w);
    end
  end

endmodule

>>> sv/speed_ramp_with_heading_trim.sv
// Two-wheel speed setpoint generator with linear ramp and gyro heading trim.
// Input stream: tuser carries the item kind (start, tick, slowdown), tdata
// carries measured speed and the two headings. A start item loads the ramp
// and answers with the target speed on both sides; a tick steps the ramp and
// answers with left/right speeds trimmed by heading error times gain; a
// slowdown item only switches the ramp mode and gives no result.
// Output stream: one result per start or tick item, left/right speed and the
// reached and slowing flags.
// Path: an accepted request is held in the input register, then takes one pass
// of ramp, multiply and clamp logic into the output register.
// Throughput: one item per cycle while results are taken; the ramp state loop closes in that cycle.
// The input side keeps accepting while a result waits, as long as the
// result register can be reloaded in the same cycle.
// Stall: a stalled receiver holds the result; the input register then holds
// its item and tready drops until the result is taken.
// Reset: ramp state cleared, registers at their reset values, both streams
// empty. Configuration writes are taken at any time, one per cycle, and are
// meant to happen while no item is in flight.
module speed_ramp_with_heading_trim (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // measured_speed, heading, target_heading
  input  logic [1:0]  s_axis_tuser,   // kind
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // left_speed, right_speed, reached_target,
                                      // slowing, zero fill
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  srht_pkg::cfg_t     cfg_q;
  logic               in_vld_q;
  srht_pkg::kind_t    kind_q;
  logic signed [15:0] meas_q;
  logic signed [24:0] err_q, err_d;
  logic               out_vld_q;
  logic [39:0]        out_data_q, out_data_d;
  logic               out_free, adv, has_result;
  srht_pkg::ramp_t    ramp;
  logic signed [15:0] left_spd, right_spd;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_speed <= '0;
      cfg_q.end_speed    <= '0;
      cfg_q.floor_speed  <= '0;
      cfg_q.ramp_step    <= srht_pkg::RampStepRst;
      cfg_q.gyro_gain    <= srht_pkg::GyroGainRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        srht_pkg::REG_TARGET_SPEED: cfg_q.target_speed <= cfg_data_i;
        srht_pkg::REG_END_SPEED:    cfg_q.end_speed    <= cfg_data_i[14:0];
        srht_pkg::REG_FLOOR_SPEED:  cfg_q.floor_speed  <= cfg_data_i[14:0];
        srht_pkg::REG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_data_i[11:0];
        srht_pkg::REG_GYRO_GAIN:    cfg_q.gyro_gain    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // handshake between input register and result register
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || adv;
  assign has_result    = (kind_q == srht_pkg::KIND_START) || (kind_q == srht_pkg::KIND_TICK);

  // heading error formed on the way in
  assign err_d = 25'(signed'(s_axis_tdata[39:16])) - 25'(signed'(s_axis_tdata[63:40]));

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      meas_q <= s_axis_tdata[15:0];
      err_q  <= err_d;
    end
  end

  srht_ramp u_ramp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .kind_i     (kind_q),
    .measured_i (meas_q),
    .cfg_i      (cfg_q),
    .ramp_o     (ramp)
  );

  srht_trim u_trim (
    .kind_i  (kind_q),
    .err_i   (err_q),
    .cfg_i   (cfg_q),
    .ramp_i  (ramp),
    .left_o  (left_spd),
    .right_o (right_spd)
  );

  // result register
  assign out_data_d = {6'd0, ramp.slowing, ramp.reached, right_spd, left_spd};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_result) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> bench/setpoint_monitor.sv
`timescale 1ns / 1ps

// watches the request, result and register channels of the speed ramp,
// predicts each setpoint from its own copy of the ramp state and compares
module setpoint_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [63:0] s_data_i,   // measured_speed, heading, target_heading
  input  logic [1:0]  s_user_i,   // kind
  // results
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,   // left_speed, right_speed, reached_target,
                                  // slowing, zero fill
  // register writes
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               reached;
    logic               slowing;
  } setpoint_t;

  // register copies
  logic signed [15:0] cfg_target;
  logic [14:0]        cfg_end;
  logic [14:0]        cfg_floor;
  logic [11:0]        cfg_step;
  logic [15:0]        cfg_gain;

  // ramp state copy
  logic signed [15:0] run_speed;
  logic               in_slowdown;
  logic               at_target;

  setpoint_t setpoints_due[$];
  setpoint_t got_sp;
  setpoint_t want_sp;
  setpoint_t next_sp;

  function automatic logic signed [15:0] clip16(input longint v);
    logic signed [15:0] r;
    if (v > 32767) begin
      r = 16'sh7fff;
    end else if (v < -32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // advance the ramp by one request; returns 1 when a setpoint comes out
  function automatic bit predict_setpoint(input srht_pkg::kind_t kind,
                                          input logic signed [15:0] meas,
                                          input logic signed [23:0] hd,
                                          input logic signed [23:0] thd,
                                          output setpoint_t res);
    int     spd;
    int     tgt;
    int     step;
    int     lim;
    longint trim;
    bit     has;
    res  = '0;
    has  = 1'b0;
    spd  = int'(run_speed);
    tgt  = int'(cfg_target);
    step = int'(cfg_step);
    case (kind)
      srht_pkg::KIND_START: begin
        // measured speed against the target direction is dropped to zero
        spd = int'(meas);
        if (tgt > 0) begin
          if (spd < 0) spd = 0;
        end else if (spd > 0) begin
          spd = 0;
        end
        in_slowdown = 1'b0;
        at_target   = 1'b0;
        res.left    = cfg_target;
        res.right   = cfg_target;
        has         = 1'b1;
      end
      srht_pkg::KIND_SLOW: begin
        in_slowdown = 1'b1;
      end
      srht_pkg::KIND_TICK: begin
        if (!in_slowdown) begin
          // ramp toward target, snap once at or past it
          if (((spd < 0) ? -spd : spd) < ((tgt < 0) ? -tgt : tgt)) begin
            spd = (tgt > 0) ? clip16(spd + step) : clip16(spd - step);
          end else begin
            spd       = tgt;
            at_target = 1'b1;
          end
        end else begin
          // head for plus or minus the larger of end and floor speed
          lim       = (cfg_end > cfg_floor) ? int'(cfg_end) : int'(cfg_floor);
          at_target = 1'b1;
          if (spd > 0) begin
            spd = (spd > lim) ? spd - step : lim;
          end else begin
            spd = (spd < -lim) ? spd + step : -lim;
          end
        end
        // heading trim, floor of error times gain over 256
        trim        = ((longint'(hd) - longint'(thd)) * longint'(cfg_gain)) >>> 8;
        res.left    = clip16(longint'(spd) - trim);
        res.right   = clip16(longint'(spd) + trim);
        has         = 1'b1;
      end
      default: ;
    endcase
    run_speed   = spd[15:0];
    res.reached = at_target;
    res.slowing = in_slowdown;
    return has;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_target  = '0;
      cfg_end     = '0;
      cfg_floor   = '0;
      cfg_step    = srht_pkg::RampStepRst;
      cfg_gain    = srht_pkg::GyroGainRst;
      run_speed   = '0;
      in_slowdown = 1'b0;
      at_target   = 1'b0;
      errors_o    = 0;
      results_o   = 0;
      setpoints_due.delete();
    end else begin
      // result side first: it can only answer an older request
      if (m_valid_i && m_ready_i) begin
        got_sp.left    = m_data_i[15:0];
        got_sp.right   = m_data_i[31:16];
        got_sp.reached = m_data_i[32];
        got_sp.slowing = m_data_i[33];
        results_o++;
        if (setpoints_due.size() == 0) begin
          report_mismatch("unrequested setpoint, left speed", 0, int'(got_sp.left));
        end else begin
          want_sp = setpoints_due.pop_front();
          if (got_sp.left != want_sp.left)
            report_mismatch("left speed", int'(want_sp.left), int'(got_sp.left));
          if (got_sp.right != want_sp.right)
            report_mismatch("right speed", int'(want_sp.right), int'(got_sp.right));
          if (got_sp.reached != want_sp.reached)
            report_mismatch("reached flag", int'(want_sp.reached), int'(got_sp.reached));
          if (got_sp.slowing != want_sp.slowing)
            report_mismatch("slowing flag", int'(want_sp.slowing), int'(got_sp.slowing));
        end
      end
      if (s_valid_i && s_ready_i) begin
        if (predict_setpoint(s_user_i, s_data_i[15:0], s_data_i[39:16], s_data_i[63:40],
                             next_sp))
          setpoints_due.push_back(next_sp);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          srht_pkg::REG_TARGET_SPEED: cfg_target = cfg_data_i;
          srht_pkg::REG_END_SPEED:    cfg_end    = cfg_data_i[14:0];
          srht_pkg::REG_FLOOR_SPEED:  cfg_floor  = cfg_data_i[14:0];
          srht_pkg::REG_RAMP_STEP:    cfg_step   = cfg_data_i[11:0];
          srht_pkg::REG_GYRO_GAIN:    cfg_gain   = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = setpoints_due.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam srht_pkg::kind_t KIND_UNUSED = 2'd3;
  localparam int unsigned TotalItems  = 1470;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit  = 500;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            s_valid = 1'b0;
  logic [63:0]     s_data = '0;
  srht_pkg::kind_t s_user = srht_pkg::KIND_START;
  logic            m_ready = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [2:0]      cfg_index = '0;
  logic [15:0]     cfg_data = '0;

  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [39:0] m_axis_tdata;
  logic        cfg_ready_o;

  int          errors;
  int          pending;
  int          results;
  int          items_sent = 0;
  int          reg_writes = 0;
  int          phases = 0;
  int unsigned quiet_cycles = 0;
  bit          no_idle = 1'b0;

  speed_ramp_with_heading_trim dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  setpoint_monitor u_monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_data),
    .s_user_i    (s_user),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result side: random back-pressure per setpoint
  initial begin
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // give up when no channel moves for too long
  always @(posedge clk) begin
    if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("speed_ramp_with_heading_trim test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request after a random gap; returns at the accepting edge
  task automatic send_item(input srht_pkg::kind_t kind, input logic [15:0] meas,
                           input logic [23:0] hd, input logic [23:0] thd);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {thd, hd, meas};
    do @(posedge clk); while (!s_axis_tready);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  // wait until every setpoint is back and the pipe has emptied
  task automatic quiesce();
    @(negedge clk);
    s_valid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic load_config(input logic [15:0] tgt, input logic [15:0] end_v,
                             input logic [15:0] floor_v, input logic [15:0] step_v,
                             input logic [15:0] gain_v);
    quiesce();
    // an index past the last register must be ignored
    write_reg(3'($urandom_range(int'(srht_pkg::REG_GYRO_GAIN) + 1,
                                (1 << srht_pkg::CfgIdxW) - 1)),
              16'($urandom));
    write_reg(srht_pkg::REG_TARGET_SPEED, tgt);
    write_reg(srht_pkg::REG_END_SPEED, end_v);
    write_reg(srht_pkg::REG_FLOOR_SPEED, floor_v);
    write_reg(srht_pkg::REG_RAMP_STEP, step_v);
    write_reg(srht_pkg::REG_GYRO_GAIN, gain_v);
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic send_tick();
    logic [23:0] hd;
    logic [23:0] dv;
    hd = 24'($urandom);
    // mostly small heading errors so the trim does not always saturate
    if ($urandom_range(0, 3) == 0) dv = 24'($urandom);
    else dv = 24'($urandom_range(0, 64) - 32);
    send_item(srht_pkg::KIND_TICK, 16'($urandom), hd, hd - dv);
  endtask

  task automatic send_start();
    logic [15:0] meas;
    case ($urandom_range(0, 3))
      0:       meas = 16'($urandom);
      1:       meas = '0;
      default: meas = 16'($urandom_range(0, 4000) - 2000);
    endcase
    send_item(srht_pkg::KIND_START, meas, 24'($urandom), 24'($urandom));
  endtask

  task automatic run_ticks(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 11) == 0)
        send_item(srht_pkg::kind_t'($urandom_range(0, 3)), 16'($urandom), 24'($urandom),
                  24'($urandom));
      send_tick();
    end
  endtask

  initial begin
    logic [15:0] tgt;
    logic [15:0] end_v;
    logic [15:0] floor_v;
    logic [15:0] step_v;
    logic [15:0] gain_v;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero target, tick snaps straight to it
    send_item(srht_pkg::KIND_TICK, '0, '0, '0);

    // full positive target, largest step and gain, trim saturation both ways
    load_config(16'sh7fff, 16'hffff, 16'h0000, 16'h0fff, 16'hffff);
    send_item(srht_pkg::KIND_START, 16'h8000, '0, '0);
    send_item(srht_pkg::KIND_TICK, '0, 24'h7fffff, 24'h800000);
    send_item(srht_pkg::KIND_TICK, 16'hffff, 24'h800000, 24'h7fffff);
    send_item(srht_pkg::KIND_START, 16'd30000, '0, '0);
    send_item(srht_pkg::KIND_TICK, '0, '0, '0);
    send_item(srht_pkg::KIND_TICK, '0, 24'hffffff, 24'hffffff);
    send_item(KIND_UNUSED, 16'hffff, 24'hffffff, 24'hffffff);
    send_item(srht_pkg::KIND_SLOW, '0, '0, '0);
    send_item(srht_pkg::KIND_TICK, '0, 24'h000001, '0);

    // overshoot past the target, then slow down to the floor
    load_config(16'd10000, 16'd3000, 16'd5000, 16'h0fff, 16'd256);
    send_item(srht_pkg::KIND_START, '0, '0, '0);
    repeat (4) send_item(srht_pkg::KIND_TICK, '0, 24'd5, '0);
    send_item(srht_pkg::KIND_SLOW, '0, '0, '0);
    repeat (3) send_item(srht_pkg::KIND_TICK, '0, '0, 24'd7);

    // negative target: positive measurement dropped, zero speed goes negative
    load_config(16'sh8000, 16'd0, 16'd100, 16'h0fff, 16'd0);
    send_item(srht_pkg::KIND_START, 16'h7fff, '0, '0);
    send_item(srht_pkg::KIND_SLOW, '0, '0, '0);
    send_item(srht_pkg::KIND_TICK, '0, 24'h123456, 24'h654321);
    send_item(srht_pkg::KIND_START, 16'hffff, '0, '0);

    // random settings, each phase a few start / ramp / slowdown runs
    while (items_sent < TotalItems) begin
      case ($urandom_range(0, 5))
        0:       tgt = 16'sh7fff;
        1:       tgt = 16'sh8000;
        2:       tgt = '0;
        default: tgt = 16'($urandom_range(0, 6000) - 3000);
      endcase
      case ($urandom_range(0, 3))
        0:       end_v = '0;
        1:       end_v = 16'h7fff;
        default: end_v = 16'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 3))
        0:       floor_v = '0;
        1:       floor_v = 16'h7fff;
        default: floor_v = 16'($urandom_range(0, 3000));
      endcase
      end_v[15]   = 1'($urandom);
      floor_v[15] = 1'($urandom);
      case ($urandom_range(0, 5))
        0:       step_v = '0;
        1:       step_v = 16'h0fff;
        default: step_v = 16'($urandom_range(1, 400));
      endcase
      step_v[15:12] = 4'($urandom);
      case ($urandom_range(0, 4))
        0:       gain_v = '0;
        1:       gain_v = 16'hffff;
        2:       gain_v = 16'd256;
        default: gain_v = 16'($urandom_range(0, 1024));
      endcase
      load_config(tgt, end_v, floor_v, step_v, gain_v);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        send_start();
        run_ticks($urandom_range(1, 30));
        if ($urandom_range(0, 2) != 0) begin
          send_item(srht_pkg::KIND_SLOW, 16'($urandom), 24'($urandom), 24'($urandom));
          run_ticks($urandom_range(1, 20));
        end
      end
    end

    quiesce();
    $display("covered %0d requests over %0d register settings (%0d writes), %0d setpoints",
             items_sent, phases, reg_writes, results);
    $display("checked, with gaps of 0 to 12 cycles on both streams and idle-free stretches");
    if (errors == 0) begin
      $display("speed_ramp_with_heading_trim test passed");
    end else begin
      $display("speed_ramp_with_heading_trim test failed");
    end
    $finish;
  end

endmodule
